// ===== rtl/bwvs_pkg.sv =====
package bwvs_pkg;

	localparam int BONE_SLOTS_DEF     = 128;
	localparam int MAX_INFLUENCES_DEF = 3;
	localparam int FRACTION_BITS_DEF  = 16;
	localparam int WEIGHT_BITS        = 16;

	typedef enum logic [1:0] {
		CMD_LOAD_POSE = 2'd0,
		CMD_LOAD_BIND = 2'd1,
		CMD_POINT     = 2'd2,
		CMD_DIRECTION = 2'd3
	} cmd_t;

	// datapath operation phases
	typedef enum logic [1:0] {
		PH_BIND = 2'd0,
		PH_POSE = 2'd1,
		PH_WGT  = 2'd2
	} phase_t;

	typedef struct packed {
		logic       start;      // latch vector, clear sums and flag
		logic       mac;        // one multiply-accumulate step
		phase_t     phase;
		logic [1:0] row;
		logic [1:0] col;
		logic [1:0] infl;
		logic       row_end;    // close row: saturate and store
		logic       wgt_add;    // add weighted term to sum
		logic       finish;     // final saturation into output register
	} dp_cmd_t;

	function automatic logic [31:0] sat32(input logic signed [65:0] v, output logic f);
		begin
			f = 1'b0;
			if (v > 66'sh0_7FFF_FFFF) begin
				f = 1'b1;
				sat32 = 32'h7FFF_FFFF;
			end else if (v < -66'sh0_8000_0000) begin
				f = 1'b1;
				sat32 = 32'h8000_0000;
			end else begin
				sat32 = v[31:0];
			end
		end
	endfunction

endpackage

// ===== rtl/bone_weighted_vertex_skinning.sv =====
// channel | signal group          | contents
// s_axis  | tvalid tready tdata   | command, address, vector, influences
// m_axis  | tvalid tready tdata   | skinned xyz, saturated
// Loads leave s_axis_tready high. A transform with n used influences runs bind,
// pose and weight steps for each influence on the one shared multiplier and read
// port, then a pipeline drain and the output load; m_axis_tvalid and s_axis_tready
// rise together after the output load.
// Reset clears control only; matrix tables are undefined until loaded.
// The result waits in the output register; while m_axis stalls, the next transform still
// runs, then holds the block in its done state and blocks further items.
module bone_weighted_vertex_skinning #(
	parameter int BONE_SLOTS     = bwvs_pkg::BONE_SLOTS_DEF,
	parameter int MAX_INFLUENCES = bwvs_pkg::MAX_INFLUENCES_DEF,
	parameter int FRACTION_BITS  = bwvs_pkg::FRACTION_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// command[1:0], word_address[12:2], vec_x[44:13], vec_y[76:45], vec_z[108:77],
	// num_influences[110:109], bone_a/b/c[131:111], weight_a/b/c[182:132]
	input  logic [183:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// out_x[31:0], out_y[63:32], out_z[95:64], saturated[96]
	output logic [103:0] m_axis_tdata
);

	logic busy, out_load, in_acc, go;
	logic [1:0] n_raw, n_cl;
	logic [31:0] ox, oy, oz;
	logic sat;
	logic valid_q, wait_q;
	bwvs_pkg::dp_cmd_t cmd;

	assign s_axis_tready = !busy && !wait_q;
	assign in_acc = s_axis_tvalid && s_axis_tready;
	assign go = in_acc && s_axis_tdata[1];
	assign n_raw = s_axis_tdata[110:109];
	assign n_cl = ({30'd0, n_raw} > MAX_INFLUENCES) ? 2'(MAX_INFLUENCES) : n_raw;

	bwvs_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .go(go), .n_infl(n_cl),
		.out_free(!valid_q && !wait_q), .busy(busy), .out_load(out_load), .cmd(cmd)
	);

	bwvs_dp #(.BONE_SLOTS(BONE_SLOTS), .FRACTION_BITS(FRACTION_BITS)) u_dp (
		.clk(clk), .command(s_axis_tdata[1:0]), .in_acc(in_acc),
		.word_address(s_axis_tdata[12:2]),
		.vec_x(s_axis_tdata[44:13]), .vec_y(s_axis_tdata[76:45]),
		.vec_z(s_axis_tdata[108:77]),
		.bone_a(s_axis_tdata[117:111]), .bone_b(s_axis_tdata[124:118]),
		.bone_c(s_axis_tdata[131:125]),
		.weight_a(s_axis_tdata[148:132]), .weight_b(s_axis_tdata[165:149]),
		.weight_c(s_axis_tdata[182:166]),
		.cmd(cmd), .out_x(ox), .out_y(oy), .out_z(oz), .saturated(sat)
	);

	// valid rises in the cycle after the output register is loaded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			wait_q <= 1'b0;
		end else begin
			wait_q <= out_load;
			if (wait_q)
				valid_q <= 1'b1;
			else if (m_axis_tready)
				valid_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata = {7'd0, sat, oz, oy, ox};

endmodule

// ===== rtl/bwvs_ctrl.sv =====
module bwvs_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              go,
	input  logic [1:0]        n_infl,
	input  logic              out_free,
	output logic              busy,
	output logic              out_load,
	output bwvs_pkg::dp_cmd_t cmd
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_BIND = 5'b00010,
		ST_POSE = 5'b00100,
		ST_WGT  = 5'b01000,
		ST_DONE = 5'b10000
	} state_t;

	state_t     state_q;
	logic [1:0] row_q, col_q, infl_q, n_q;

	assign busy = (state_q != ST_IDLE);

	always_comb begin
		cmd = '0;
		cmd.row = row_q;
		cmd.col = col_q;
		cmd.infl = infl_q;
		cmd.start = go;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: ;
			ST_BIND: begin
				cmd.mac = 1'b1;
				cmd.phase = bwvs_pkg::PH_BIND;
				cmd.row_end = (col_q == 2'd3);
			end
			ST_POSE: begin
				cmd.mac = 1'b1;
				cmd.phase = bwvs_pkg::PH_POSE;
				cmd.row_end = (col_q == 2'd3);
			end
			ST_WGT: begin
				cmd.mac = 1'b1;
				cmd.phase = bwvs_pkg::PH_WGT;
				cmd.wgt_add = 1'b1;
			end
			ST_DONE: begin
				cmd.finish = out_free && (row_q == 2'd2);
				out_load = out_free && (row_q == 2'd2);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			row_q <= '0;
			col_q <= '0;
			infl_q <= '0;
			n_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (go) begin
						n_q <= n_infl;
						infl_q <= '0;
						row_q <= '0;
						col_q <= '0;
						state_q <= (n_infl == 2'd0) ? ST_DONE : ST_BIND;
					end
				end
				ST_BIND: begin
					col_q <= col_q + 2'd1;
					if (col_q == 2'd3) begin
						row_q <= row_q + 2'd1;
						if (row_q == 2'd3) begin
							row_q <= '0;
							state_q <= ST_POSE;
						end
					end
				end
				ST_POSE: begin
					col_q <= col_q + 2'd1;
					if (col_q == 2'd3) begin
						row_q <= row_q + 2'd1;
						if (row_q == 2'd2) begin
							row_q <= '0;
							state_q <= ST_WGT;
						end
					end
				end
				ST_WGT: begin
					row_q <= row_q + 2'd1;
					if (row_q == 2'd2) begin
						row_q <= '0;
						infl_q <= infl_q + 2'd1;
						state_q <= (infl_q + 2'd1 == n_q) ? ST_DONE : ST_BIND;
					end
				end
				ST_DONE: begin
					// row counter times the multiplier pipeline drain
					if (row_q != 2'd2)
						row_q <= row_q + 2'd1;
					else if (out_free) begin
						row_q <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/bwvs_dp.sv =====
module bwvs_dp #(
	parameter int BONE_SLOTS    = bwvs_pkg::BONE_SLOTS_DEF,
	parameter int FRACTION_BITS = bwvs_pkg::FRACTION_BITS_DEF
) (
	input  logic              clk,
	input  logic [1:0]        command,
	input  logic              in_acc,
	input  logic [10:0]       word_address,
	input  logic [31:0]       vec_x,
	input  logic [31:0]       vec_y,
	input  logic [31:0]       vec_z,
	input  logic [6:0]        bone_a,
	input  logic [6:0]        bone_b,
	input  logic [6:0]        bone_c,
	input  logic [16:0]       weight_a,
	input  logic [16:0]       weight_b,
	input  logic [16:0]       weight_c,
	input  bwvs_pkg::dp_cmd_t cmd,
	output logic [31:0]       out_x,
	output logic [31:0]       out_y,
	output logic [31:0]       out_z,
	output logic              saturated
);

	localparam int WORDS = BONE_SLOTS * 16;
	localparam int AW = $clog2(WORDS);
	localparam int SW = (BONE_SLOTS > 1) ? $clog2(BONE_SLOTS) : 1;
	localparam logic [SW-1:0] SLOT_MAX = SW'(BONE_SLOTS - 1);
	localparam int WEIGHT_SHIFT = bwvs_pkg::WEIGHT_BITS;

	logic [31:0] pose_mem [WORDS];
	logic [31:0] bind_mem [WORDS];

	logic [31:0] v_q [4];
	logic [31:0] t_q [4];
	logic [31:0] p_q [3];
	logic signed [65:0] sum_q [3];
	logic signed [65:0] acc_q;
	logic [SW-1:0] bone_q [3];
	logic [16:0] wgt_q [3];
	logic flag_q;

	// memory read stage
	logic [31:0] rd_pose_s1, rd_bind_s1;
	logic        mac_s1;
	bwvs_pkg::dp_cmd_t cmd_s1;

	logic [SW-1:0] cur_bone;
	logic [AW-1:0] rd_addr;

	function automatic logic [SW-1:0] clamp_bone(input logic [6:0] b);
		begin
			if ({25'd0, b} >= BONE_SLOTS)
				clamp_bone = SLOT_MAX;
			else
				clamp_bone = b[SW-1:0];
		end
	endfunction

	assign cur_bone = bone_q[cmd.infl];
	if (AW > 4) begin : g_addr
		assign rd_addr = {cur_bone[AW-5:0], cmd.row, cmd.col};
	end else begin : g_addr1
		assign rd_addr = {cmd.row, cmd.col};
	end

	always_ff @(posedge clk) begin
		if (in_acc && command[1] == 1'b0 && {21'd0, word_address} < WORDS) begin
			if (command[0])
				bind_mem[word_address[AW-1:0]] <= vec_x;
			else
				pose_mem[word_address[AW-1:0]] <= vec_x;
		end
		rd_pose_s1 <= pose_mem[rd_addr];
		rd_bind_s1 <= bind_mem[rd_addr];
	end

	// product stage
	logic signed [31:0] opa;
	logic signed [32:0] opb;
	logic signed [65:0] prod_s2;
	logic signed [65:0] rnd;
	logic        f1, f2;
	logic [31:0] s1v, s2v;
	bwvs_pkg::dp_cmd_t cmd_s2;

	always_comb begin
		opa = '0;
		opb = '0;
		unique case (cmd_s1.phase)
			bwvs_pkg::PH_BIND: begin
				opa = rd_bind_s1;
				opb = {v_q[cmd_s1.col][31], v_q[cmd_s1.col]};
			end
			bwvs_pkg::PH_POSE: begin
				opa = rd_pose_s1;
				opb = {t_q[cmd_s1.col][31], t_q[cmd_s1.col]};
			end
			default: begin
				opa = p_q[cmd_s1.row];
				opb = {16'd0, wgt_q[cmd_s1.infl]};
			end
		endcase
	end

	always_ff @(posedge clk) begin
		cmd_s1 <= cmd;
		cmd_s2 <= cmd_s1;
		mac_s1 <= cmd.mac;
		if (mac_s1)
			prod_s2 <= 66'(opa * opb);
	end

	always_comb begin
		if (cmd_s2.phase == bwvs_pkg::PH_WGT)
			rnd = (prod_s2 + (66'sd1 <<< (WEIGHT_SHIFT - 1))) >>> WEIGHT_SHIFT;
		else
			rnd = (prod_s2 + (66'sd1 <<< (FRACTION_BITS - 1))) >>> FRACTION_BITS;
		s1v = bwvs_pkg::sat32(acc_q + rnd, f1);
		s2v = bwvs_pkg::sat32(rnd, f2);
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			v_q[0] <= vec_x;
			v_q[1] <= vec_y;
			v_q[2] <= vec_z;
			v_q[3] <= (command == bwvs_pkg::CMD_POINT) ? (32'd1 << FRACTION_BITS) : 32'd0;
			bone_q[0] <= clamp_bone(bone_a);
			bone_q[1] <= clamp_bone(bone_b);
			bone_q[2] <= clamp_bone(bone_c);
			wgt_q[0] <= weight_a;
			wgt_q[1] <= weight_b;
			wgt_q[2] <= weight_c;
			for (int k = 0; k < 3; k++)
				sum_q[k] <= '0;
			acc_q <= '0;
			flag_q <= 1'b0;
		end else if (cmd_s2.mac) begin
			if (cmd_s2.wgt_add) begin
				sum_q[cmd_s2.row] <= sum_q[cmd_s2.row] + {{34{s2v[31]}}, s2v};
				if (f2)
					flag_q <= 1'b1;
			end else if (cmd_s2.row_end) begin
				acc_q <= '0;
				if (f1)
					flag_q <= 1'b1;
				if (cmd_s2.phase == bwvs_pkg::PH_BIND)
					t_q[cmd_s2.row] <= s1v;
				else
					p_q[cmd_s2.row] <= s1v;
			end else begin
				acc_q <= acc_q + rnd;
			end
		end
		if (cmd.finish) begin
			logic fx, fy, fz;
			out_x <= bwvs_pkg::sat32(sum_q[0], fx);
			out_y <= bwvs_pkg::sat32(sum_q[1], fy);
			out_z <= bwvs_pkg::sat32(sum_q[2], fz);
			saturated <= flag_q | fx | fy | fz;
		end
	end

endmodule

// ===== rtl/bwvs_checker.sv =====
module bwvs_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tready,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [103:0] m_axis_tdata
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output word dropped under stall");
	a_known: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown({s_axis_tready, m_axis_tvalid}))
		else $error("handshake output unknown");
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[103:97] == 7'd0)
		else $error("padding bits set");
endmodule

bind bone_weighted_vertex_skinning bwvs_checker u_chk (
	.clk(clk), .arst_n(arst_n),
	.s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);

// ===== tb/tb_bone_weighted_vertex_skinning.sv =====
`timescale 1ns / 100ps

module tb_bone_weighted_vertex_skinning;

	localparam int SLOTS = 128;
	localparam int WORDS = SLOTS * 16;
	localparam int FB    = 16;

	typedef struct {
		bwvs_pkg::cmd_t     cmd;
		logic [10:0]        addr;
		logic signed [31:0] x, y, z;
		logic [1:0]         n;
		logic [6:0]         bone_a, bone_b, bone_c;
		logic [16:0]        wgt_a, wgt_b, wgt_c;
		bit                 drain;
	} vtx_item_t;

	typedef struct {
		logic [31:0] x, y, z;
		logic        sat;
	} skin_out_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [183:0] s_axis_tdata = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [103:0] m_axis_tdata;

	bone_weighted_vertex_skinning dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always #1 clk = ~clk;

	vtx_item_t   pending_items[$];
	skin_out_t   expected_skin[$];
	vtx_item_t   cur_item;
	logic [31:0] pose_mem [WORDS];
	logic [31:0] bind_mem [WORDS];
	bit          gen_pose_wr [WORDS];
	bit          gen_bind_wr [WORDS];
	int          ready_bones[$];
	int          offered = 0;
	int          accepted = 0;
	int          errors = 0;
	int          checked = 0;
	int          sat_seen = 0;
	int          loads_seen = 0;
	int          cyc = 0;
	int          hold_cnt = 0;
	bit          hold_done = 1'b0;
	bit          gen_done = 1'b0;

	wire quiet = (cyc >= 3000 && cyc < 6000);

	function automatic logic [183:0] pack_item(input vtx_item_t it);
		return {1'b0, it.wgt_c, it.wgt_b, it.wgt_a, it.bone_c, it.bone_b, it.bone_a,
			it.n, it.z, it.y, it.x, it.addr, it.cmd};
	endfunction

	function automatic longint round16(input longint v);
		return (v + (64'sd1 <<< (FB - 1))) >>> FB;
	endfunction

	function automatic longint clip32(input longint v, inout logic f);
		if (v > 64'sd2147483647) begin
			f = 1'b1;
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			f = 1'b1;
			return -64'sd2147483648;
		end
		return v;
	endfunction

	function automatic skin_out_t skin_vertex(input vtx_item_t it);
		longint    v[4], t[4], p[3], sum[3], acc, w;
		int        bone;
		logic      f;
		skin_out_t r;
		f = 1'b0;
		v[0] = longint'(it.x);
		v[1] = longint'(it.y);
		v[2] = longint'(it.z);
		v[3] = (it.cmd == bwvs_pkg::CMD_POINT) ? (64'sd1 <<< FB) : 64'sd0;
		sum[0] = 0; sum[1] = 0; sum[2] = 0;
		for (int i = 0; i < int'(it.n); i++) begin
			bone = (i == 0) ? it.bone_a : (i == 1) ? it.bone_b : it.bone_c;
			w = (i == 0) ? it.wgt_a : (i == 1) ? it.wgt_b : it.wgt_c;
			for (int rr = 0; rr < 4; rr++) begin
				acc = 0;
				for (int c = 0; c < 4; c++)
					acc += round16(longint'($signed(bind_mem[bone*16 + rr*4 + c])) * v[c]);
				t[rr] = clip32(acc, f);
			end
			for (int rr = 0; rr < 3; rr++) begin
				acc = 0;
				for (int c = 0; c < 4; c++)
					acc += round16(longint'($signed(pose_mem[bone*16 + rr*4 + c])) * t[c]);
				p[rr] = clip32(acc, f);
			end
			for (int k = 0; k < 3; k++)
				sum[k] += clip32(round16(p[k] * w), f);
		end
		r.x = clip32(sum[0], f);
		r.y = clip32(sum[1], f);
		r.z = clip32(sum[2], f);
		r.sat = f;
		return r;
	endfunction

	function automatic logic [31:0] rand_word();
		case ($urandom % 5)
			0: return $urandom;
			1: return 32'($urandom_range(0, 1 << 18)) - 32'(1 << 17);
			2: return 32'($urandom_range(0, 1 << 21)) - 32'(1 << 20);
			3: return 32'($urandom_range(0, 2 << 16)) - 32'(1 << 16);
			default: case ($urandom % 4)
				0: return 32'h7FFF_FFFF;
				1: return 32'h8000_0000;
				2: return 32'h0001_0000;
				default: return 32'h0;
			endcase
		endcase
	endfunction

	function automatic logic [16:0] rand_weight();
		case ($urandom % 6)
			0: return 17'd65536;
			1: return 17'd0;
			2: return 17'($urandom);
			default: return 17'($urandom_range(0, 65536));
		endcase
	endfunction

	task automatic push_load(input bwvs_pkg::cmd_t c, input int a, input logic [31:0] w);
		vtx_item_t it;
		it = '{cmd: c, addr: 11'(a), x: w, default: '0};
		it.y = $urandom;
		it.z = $urandom;
		it.n = $urandom;
		it.bone_a = $urandom; it.bone_b = $urandom; it.bone_c = $urandom;
		it.wgt_a = $urandom; it.wgt_b = $urandom; it.wgt_c = $urandom;
		if (c == bwvs_pkg::CMD_LOAD_POSE)
			gen_pose_wr[a] = 1'b1;
		else
			gen_bind_wr[a] = 1'b1;
		pending_items = {pending_items, it};
	endtask

	task automatic note_ready(input int b);
		bit ok;
		ok = 1'b1;
		for (int k = 0; k < 16; k++) begin
			if (!gen_bind_wr[b*16 + k])
				ok = 1'b0;
			if (k < 12 && !gen_pose_wr[b*16 + k])
				ok = 1'b0;
		end
		if (ok && !(b inside {ready_bones}))
			ready_bones = {ready_bones, b};
	endtask

	task automatic load_bone(input int b, input bit ident);
		for (int k = 0; k < 16; k++) begin
			push_load(bwvs_pkg::CMD_LOAD_BIND, b*16 + k,
				ident ? ((k % 5 == 0) ? 32'h0001_0000 : 32'h0) : rand_word());
			push_load(bwvs_pkg::CMD_LOAD_POSE, b*16 + k,
				ident ? ((k % 5 == 0) ? 32'h0002_0000 : (k == 3 ? 32'h0003_8000 : 32'h0))
				: rand_word());
		end
		note_ready(b);
	endtask

	task automatic push_xform(input bwvs_pkg::cmd_t c, input logic [31:0] x, y, z,
			input int n, input int ba, bb, bc, input logic [16:0] wa, wb, wc);
		vtx_item_t it;
		it = '{cmd: c, addr: 11'($urandom), x: x, y: y, z: z, n: 2'(n),
			bone_a: 7'(ba), bone_b: 7'(bb), bone_c: 7'(bc),
			wgt_a: wa, wgt_b: wb, wgt_c: wc, drain: 1'b0};
		pending_items = {pending_items, it};
	endtask

	task automatic push_rand_xform();
		int n, b[3];
		n = (ready_bones.size() == 0) ? 0 : $urandom_range(0, 3);
		for (int i = 0; i < 3; i++)
			b[i] = (i < n) ? ready_bones[$urandom % ready_bones.size()] : $urandom_range(0, 127);
		push_xform(($urandom % 2) ? bwvs_pkg::CMD_POINT : bwvs_pkg::CMD_DIRECTION,
			rand_word(), rand_word(), rand_word(), n, b[0], b[1], b[2],
			rand_weight(), rand_weight(), rand_weight());
	endtask

	// stimulus
	initial begin
		vtx_item_t drain_it;
		int        a;
		bit        drain_added;
		drain_added = 1'b0;
		load_bone(0, 1'b1);
		load_bone(127, 1'b0);
		push_xform(bwvs_pkg::CMD_POINT, 32'h0001_0000, 32'hFFFE_0000, 32'h0000_8000, 0,
			0, 0, 0, 17'd65536, 17'd65536, 17'd65536);
		push_xform(bwvs_pkg::CMD_POINT, 32'h0001_0000, 32'hFFFE_0000, 32'h0000_8000, 1,
			0, 0, 0, 17'd65536, 17'd0, 17'd0);
		push_xform(bwvs_pkg::CMD_DIRECTION, 32'h0001_0000, 32'hFFFE_0000, 32'h0000_8000, 1,
			0, 0, 0, 17'd65536, 17'd0, 17'd0);
		push_xform(bwvs_pkg::CMD_POINT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 3,
			0, 127, 0, 17'd65536, 17'd131071, 17'd0);
		push_xform(bwvs_pkg::CMD_DIRECTION, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 3,
			127, 127, 0, 17'd131071, 17'd65536, 17'd1);
		push_xform(bwvs_pkg::CMD_POINT, 32'h0, 32'h0, 32'h0, 2,
			0, 127, 5, 17'd32768, 17'd32768, 17'd0);
		push_xform(bwvs_pkg::CMD_POINT, 32'hFFFF_FFFF, 32'h1, 32'h0, 3,
			0, 0, 0, 17'd21845, 17'd21845, 17'd21846);
		while (pending_items.size() < 600) begin
			a = $urandom % 100;
			if (a < 6 || ready_bones.size() < 4)
				load_bone($urandom_range(0, 127), 1'b0);
			else if (a < 14) begin
				a = $urandom_range(0, WORDS - 1);
				push_load(($urandom % 2) ? bwvs_pkg::CMD_LOAD_POSE : bwvs_pkg::CMD_LOAD_BIND,
					a, rand_word());
				note_ready(a / 16);
			end else
				push_rand_xform();
			if (!drain_added && pending_items.size() >= 380) begin
				drain_it = '{cmd: bwvs_pkg::CMD_LOAD_POSE, drain: 1'b1, default: '0};
				pending_items = {pending_items, drain_it};
				drain_added = 1'b1;
			end
		end
		gen_done = 1'b1;
	end

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	always @(posedge clk)
		cyc <= cyc + 1;

	// sender
	always @(negedge clk) begin
		if (arst_n && (!s_axis_tvalid || accepted == offered)) begin
			if (pending_items.size() != 0 && pending_items[0].drain) begin
				s_axis_tvalid <= 1'b0;
				if (expected_skin.size() == 0 && !s_axis_tvalid)
					void'(pending_items.pop_front());
			end else if (pending_items.size() != 0 && (quiet || $urandom % 100 >= 13)) begin
				cur_item <= pending_items[0];
				s_axis_tdata <= pack_item(pending_items.pop_front());
				s_axis_tvalid <= 1'b1;
				offered <= offered + 1;
			end else
				s_axis_tvalid <= 1'b0;
		end
	end

	// receiver
	always @(negedge clk) begin
		if (!hold_done && accepted >= 300) begin
			hold_done <= 1'b1;
			hold_cnt <= 400;
			m_axis_tready <= 1'b0;
		end else if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
			m_axis_tready <= 1'b0;
		end else
			m_axis_tready <= arst_n && (quiet || $urandom % 100 >= 13);
	end

	// model update and result check
	always @(posedge clk) begin
		skin_out_t e;
		if (s_axis_tvalid && s_axis_tready) begin
			accepted <= accepted + 1;
			case (cur_item.cmd)
				bwvs_pkg::CMD_LOAD_POSE: begin
					pose_mem[cur_item.addr] = cur_item.x;
					loads_seen++;
				end
				bwvs_pkg::CMD_LOAD_BIND: begin
					bind_mem[cur_item.addr] = cur_item.x;
					loads_seen++;
				end
				default: expected_skin = {expected_skin, skin_vertex(cur_item)};
			endcase
		end
		if (m_axis_tvalid && m_axis_tready) begin
			if (expected_skin.size() == 0) begin
				$display("%0t: unexpected word %h", $time, m_axis_tdata);
				errors++;
			end else begin
				e = expected_skin.pop_front();
				checked++;
				if (e.sat)
					sat_seen++;
				if (m_axis_tdata[31:0] !== e.x)
					$display("%0t: out_x expected %h actual %h", $time, e.x, m_axis_tdata[31:0]);
				if (m_axis_tdata[63:32] !== e.y)
					$display("%0t: out_y expected %h actual %h", $time, e.y, m_axis_tdata[63:32]);
				if (m_axis_tdata[95:64] !== e.z)
					$display("%0t: out_z expected %h actual %h", $time, e.z, m_axis_tdata[95:64]);
				if (m_axis_tdata[96] !== e.sat)
					$display("%0t: saturated expected %b actual %b", $time, e.sat,
						m_axis_tdata[96]);
				if (m_axis_tdata[95:0] !== {e.z, e.y, e.x} || m_axis_tdata[96] !== e.sat)
					errors++;
			end
		end
	end

	initial begin
		wait (gen_done);
		wait (pending_items.size() == 0 && accepted == offered);
		wait (expected_skin.size() == 0);
		repeat (200) @(posedge clk);
		if (expected_skin.size() != 0) begin
			$display("%0t: %0d results missing", $time, expected_skin.size());
			errors++;
		end
		$display("ran %0d words: %0d matrix loads, %0d skinned vertices (%0d clipped)",
			accepted, loads_seen, checked, sat_seen);
		if (errors == 0)
			$display("tb_bone_weighted_vertex_skinning OK");
		else
			$display("tb_bone_weighted_vertex_skinning NOT OK");
		$finish;
	end

	initial begin
		#3000000;
		$display("timeout");
		$display("tb_bone_weighted_vertex_skinning NOT OK");
		$finish;
	end

endmodule
